>>> rtl/dcd_pkg.sv
// shared types, constants and helpers for the detection candidate decoder
`default_nettype none

package dcd_pkg;

  localparam int DefMaxColumns = 128;
  localparam int DefMaxRows    = 65535;

  localparam int ValueW  = 18;
  localparam int ScoreW  = 20;
  localparam int ConfW   = 19;
  localparam int ClassW  = 7;
  localparam int RowOutW = 16;
  localparam int BoxW    = 16;
  localparam int ProdW   = 2 * ValueW;
  localparam int DeltaW  = ValueW + 2;
  localparam int BoxPW   = DeltaW + 15;
  localparam int CfgDataW  = 17;
  localparam int CfgIndexW = 3;
  localparam int CfgColsW  = 8;
  localparam int CfgRowsW  = 16;
  localparam int InTdataW  = 24;
  localparam int OutTdataW = 112;

  localparam int MinColumns = 6;

  localparam logic [16:0] ThrReset  = 17'd16384;
  localparam logic [13:0] ImgReset  = 14'd640;
  localparam logic [7:0]  ColsReset = 8'd85;
  localparam logic [15:0] RowsReset = 16'd25200;

  // column positions within a row
  localparam int ColCenterX = 0;
  localparam int ColCenterY = 1;
  localparam int ColSizeW   = 2;
  localparam int ColSizeH   = 3;
  localparam int ColObj     = 4;
  localparam int ColClass0  = 5;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_IMG_WIDTH = 3'd1,
    CFG_IMG_HEIGHT = 3'd2,
    CFG_COLUMNS   = 3'd3,
    CFG_ROWS      = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [16:0] thr;
    logic [13:0] img_w;
    logic [13:0] img_h;
    logic [7:0]  cols;
    logic [15:0] rows;
  } cfg_t;

  typedef struct packed {
    logic signed [ProdW-1:0]  prod;
    logic                     is_class;
    logic                     first;
    logic [ClassW-1:0]        cls;
    logic                     last;
    logic [RowOutW-1:0]       row;
    logic signed [ValueW-1:0] obj;
    logic signed [DeltaW-1:0] dx;
    logic signed [DeltaW-1:0] dy;
    logic signed [ValueW-1:0] sw;
    logic signed [ValueW-1:0] sh;
  } s1_t;

  typedef struct packed {
    logic                    pass;
    logic signed [BoxPW-1:0] left_p;
    logic signed [BoxPW-1:0] top_p;
    logic signed [BoxPW-1:0] w_p;
    logic signed [BoxPW-1:0] h_p;
    logic [ConfW-1:0]        conf;
    logic [ClassW-1:0]       cls;
    logic [RowOutW-1:0]      row;
  } s2_t;

  // shift right rounding toward zero, then clamp to 16 bits signed
  function automatic logic signed [BoxW-1:0] trunc_sat(input logic signed [BoxPW-1:0] p,
                                                       input int k);
    logic signed [BoxPW-1:0] bias;
    logic signed [BoxPW-1:0] q;
    bias = p[BoxPW-1] ? ((BoxPW'(1) <<< k) - BoxPW'(1)) : '0;
    q = (p + bias) >>> k;
    if (q > BoxPW'(32767)) begin
      trunc_sat = 16'sh7fff;
    end else if (q < -BoxPW'(32768)) begin
      trunc_sat = -16'sh8000;
    end else begin
      trunc_sat = q[BoxW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/dcd_cfg_regs.sv
// configuration register bank
`default_nettype none

module dcd_cfg_regs
  import dcd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CfgIndexW-1:0] cfg_index,
  input  wire logic [CfgDataW-1:0]  cfg_data,
  output cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.thr   <= ThrReset;
      cfg.img_w <= ImgReset;
      cfg.img_h <= ImgReset;
      cfg.cols  <= ColsReset;
      cfg.rows  <= RowsReset;
    end else if (cfg_wr_en) begin
      case (cfg_reg_e'(cfg_index))
        CFG_THRESHOLD:  cfg.thr   <= cfg_data[16:0];
        CFG_IMG_WIDTH:  cfg.img_w <= cfg_data[13:0];
        CFG_IMG_HEIGHT: cfg.img_h <= cfg_data[13:0];
        CFG_COLUMNS:    cfg.cols  <= cfg_data[7:0];
        CFG_ROWS:       cfg.rows  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/dcd_row_stage.sv
// row and column tracking, box field capture and class score product
`default_nettype none

module dcd_row_stage
  import dcd_pkg::*;
#(
  parameter int MAX_COLUMNS = DefMaxColumns,
  parameter int MAX_ROWS    = DefMaxRows
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire cfg_t                     cfg,
  input  wire logic                     in_valid,
  input  wire logic signed [ValueW-1:0] in_value,
  input  wire logic                     load,
  output logic                          s1_valid,
  output s1_t                           s1
);

  localparam int CntW = $clog2(MAX_COLUMNS);
  localparam int CmpW = ((CntW > CfgColsW) ? CntW : CfgColsW) + 1;
  localparam int RowW = $clog2(MAX_ROWS + 1);
  localparam int RcmpW = ((RowW > CfgRowsW) ? RowW : CfgRowsW) + 1;

  logic [CntW-1:0]          col;
  logic [RowW-1:0]          row;
  logic signed [ValueW-1:0] cx, cy, sw, sh, obj;

  logic [CmpW-1:0]          col_ext, cols_raw, cols_eff;
  logic [RcmpW-1:0]         rows_raw, rows_eff, row_inc;
  logic                     last, accept;
  logic signed [ProdW-1:0]  prod;

  assign accept = in_valid && load;

  always_comb begin
    col_ext  = CmpW'(col);
    cols_raw = CmpW'(cfg.cols);
    if (cols_raw < CmpW'(MinColumns)) begin
      cols_eff = CmpW'(MinColumns);
    end else if (cols_raw > CmpW'(MAX_COLUMNS)) begin
      cols_eff = CmpW'(MAX_COLUMNS);
    end else begin
      cols_eff = cols_raw;
    end
    last = (col_ext >= cols_eff - CmpW'(1));

    rows_raw = RcmpW'(cfg.rows);
    if (rows_raw < RcmpW'(1)) begin
      rows_eff = RcmpW'(1);
    end else if (rows_raw > RcmpW'(MAX_ROWS)) begin
      rows_eff = RcmpW'(MAX_ROWS);
    end else begin
      rows_eff = rows_raw;
    end
    row_inc = RcmpW'(row) + RcmpW'(1);

    prod = in_value * obj;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      cx  <= '0;
      cy  <= '0;
      sw  <= '0;
      sh  <= '0;
      obj <= '0;
    end else if (accept) begin
      if (col_ext == CmpW'(ColCenterX)) cx  <= in_value;
      if (col_ext == CmpW'(ColCenterY)) cy  <= in_value;
      if (col_ext == CmpW'(ColSizeW))   sw  <= in_value;
      if (col_ext == CmpW'(ColSizeH))   sh  <= in_value;
      if (col_ext == CmpW'(ColObj))     obj <= in_value;
      if (last) begin
        col <= '0;
        row <= (row_inc >= rows_eff) ? '0 : row_inc[RowW-1:0];
      end else begin
        col <= col + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.prod     <= prod;
      s1.is_class <= (col_ext >= CmpW'(ColClass0));
      s1.first    <= (col_ext == CmpW'(ColClass0));
      s1.cls      <= ClassW'(col_ext - CmpW'(ColClass0));
      s1.last     <= last;
      s1.row      <= RowOutW'(row);
      s1.obj      <= obj;
      s1.dx       <= {cx[ValueW-1], cx, 1'b0} - {{2{sw[ValueW-1]}}, sw};
      s1.dy       <= {cy[ValueW-1], cy, 1'b0} - {{2{sh[ValueW-1]}}, sh};
      s1.sw       <= sw;
      s1.sh       <= sh;
    end
  end

endmodule

`default_nettype wire

>>> rtl/dcd_score_stage.sv
// best class tracking, threshold test and box scaling products
`default_nettype none

module dcd_score_stage
  import dcd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire logic s1_valid,
  input  wire s1_t  s1,
  input  wire logic load,
  output logic      s2_valid,
  output s2_t       s2
);

  logic signed [ScoreW-1:0] best;
  logic [ClassW-1:0]        best_cls;

  logic signed [ProdW-1:0]  bias, adj;
  logic signed [ScoreW-1:0] score, best_next, thr_s;
  logic [ClassW-1:0]        cls_next;
  logic                     pass, step;
  logic signed [15:0]       iw, ih;
  logic signed [DeltaW-1:0] sw_x, sh_x;

  assign step = s1_valid && load;

  always_comb begin
    bias  = s1.prod[ProdW-1] ? ProdW'(16'hffff) : '0;
    adj   = s1.prod + bias;
    score = adj[ProdW-1:16];
    best_next = best;
    cls_next  = best_cls;
    if (s1.is_class && (s1.first || score > best)) begin
      best_next = score;
      cls_next  = s1.cls;
    end
    thr_s = $signed({3'b000, cfg.thr});
    pass  = s1.last
         && ($signed({s1.obj[ValueW-1], s1.obj}) > $signed({2'b00, cfg.thr}))
         && (best_next > thr_s);
    iw   = $signed({2'b00, cfg.img_w});
    ih   = $signed({2'b00, cfg.img_h});
    sw_x = {{2{s1.sw[ValueW-1]}}, s1.sw};
    sh_x = {{2{s1.sh[ValueW-1]}}, s1.sh};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best     <= '0;
      best_cls <= '0;
    end else if (step) begin
      best     <= best_next;
      best_cls <= cls_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (load) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      s2.pass   <= pass;
      s2.left_p <= BoxPW'(s1.dx * iw);
      s2.top_p  <= BoxPW'(s1.dy * ih);
      s2.w_p    <= BoxPW'(sw_x * iw);
      s2.h_p    <= BoxPW'(sh_x * ih);
      s2.conf   <= best_next[ConfW-1:0];
      s2.cls    <= cls_next;
      s2.row    <= s1.row;
    end
  end

endmodule

`default_nettype wire

>>> rtl/dcd_out_stage.sv
// box rounding and clamping into the result register
`default_nettype none

module dcd_out_stage
  import dcd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s2_valid,
  input  wire s2_t                  s2,
  input  wire logic                 m_axis_tready,
  output logic                      m_axis_tvalid,
  output logic [OutTdataW-1:0]      m_axis_tdata,
  output logic                      load
);

  logic take;

  assign load = !m_axis_tvalid || m_axis_tready;
  assign take = s2_valid && s2.pass;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (load && take) begin
      m_axis_tdata <= {6'b000000, s2.row, s2.cls, s2.conf,
                       trunc_sat(s2.h_p, 16), trunc_sat(s2.w_p, 16),
                       trunc_sat(s2.top_p, 17), trunc_sat(s2.left_p, 17)};
    end
  end

endmodule

`default_nettype wire

>>> rtl/detection_candidate_decode.sv
// Detection candidate decoder, top level.
// Prediction rows stream in on the slave side one value per word: center x,
// center y, width, height, objectness, then one score per class, all signed
// Q2.16. Each class score is scaled by objectness and the largest product
// (first class on ties) is kept. At the last column of a row one candidate
// word leaves on the master side if objectness and the best product both
// exceed the threshold; other rows give no word. The box is scaled to
// pixels by the image size, rounded toward zero and clamped to 16 bits.
// The user must write registers through cfg_wr_en/cfg_index/cfg_data while
// idle; the block does not enforce this. A value is taken every cycle unless
// input stalls. A candidate passes three registers: one for the score
// product, one for the best-score compare and box products, one for rounding
// into the result register. A waiting result holds the result register;
// rows that give no result keep flowing, and input stalls only once the
// stages behind the held result are full. Reset restores register defaults
// and clears the row and column counters and all row state.
`default_nettype none

module detection_candidate_decode
  import dcd_pkg::*;
#(
  parameter int MAX_COLUMNS = DefMaxColumns,
  parameter int MAX_ROWS    = DefMaxRows
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CfgIndexW-1:0] cfg_index,
  input  wire logic [CfgDataW-1:0]  cfg_data,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // pred_value[17:0], zeros above
  input  wire logic [InTdataW-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // box_left[15:0], box_top[31:16], box_width[47:32], box_height[63:48],
  // confidence[82:64], class_id[89:83], row_index[105:90], zeros above
  output logic [OutTdataW-1:0]      m_axis_tdata
);

  cfg_t cfg;
  s1_t  s1;
  s2_t  s2;
  logic s1_valid, s2_valid;
  logic out_load, s2_load, s1_load;

  assign s2_load = !s2_valid || !s2.pass || out_load;
  assign s1_load = !s1_valid || s2_load;
  assign s_axis_tready = s1_load;

  dcd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dcd_row_stage #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_row (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_axis_tvalid),
    .in_value ($signed(s_axis_tdata[ValueW-1:0])),
    .load     (s1_load),
    .s1_valid (s1_valid),
    .s1       (s1)
  );

  dcd_score_stage u_score (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s1_valid (s1_valid),
    .s1       (s1),
    .load     (s2_load),
    .s2_valid (s2_valid),
    .s2       (s2)
  );

  dcd_out_stage u_out (
    .clk           (clk),
    .rst           (rst),
    .s2_valid      (s2_valid),
    .s2            (s2),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .load          (out_load)
  );

endmodule

`default_nettype wire
